// ===== rtl/ric_pkg.sv =====
// Shared widths, codes and word types for the reference-counted inode cache.
package ric_pkg;

  localparam int CMD_W   = 2;
  localparam int DEV_W   = 8;
  localparam int INO_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = 6;
  localparam int BLK_W   = 32;
  localparam int OFF_W   = 3;   // eight inodes to a disk block
  localparam int REFS_W  = 16;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;
  localparam logic [REFS_W-1:0] REFS_ONE = REFS_W'(1);

  // Request codes
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISS      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_HELD      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CLEAN     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_WRITEBACK = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FREE      = 3'd6;
  localparam logic [STAT_W-1:0] STAT_MARKED    = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  inode_number;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry;
    logic [BLK_W-1:0]   disk_block;
    logic [OFF_W-1:0]   block_offset;
  } rsp_t;

  typedef logic [BLK_W-1:0] cfg_word_t;

  // Broadcast from the controller to every cell; key is inode number minus one
  typedef struct packed {
    logic              commit;
    logic [CMD_W-1:0]  cmd;
    logic              hit_any;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  key;
  } cell_op_t;

  // What a cell shows when it is the addressed slot; all zero otherwise
  typedef struct packed {
    logic             live_sel;
    logic             last_ref;
    logic             dirty;
    logic [INO_W-1:0] key;
  } cell_view_t;

endpackage

// ===== rtl/ric_stream_if.sv =====
// Valid/ready channel carrying one word of a given type.
interface ric_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/refcounted_inode_cache.sv =====
// Top level of the reference-counted inode cache: controller, cell row, result register.
//
// Channels: req (sink) takes a request word {cmd, device, inode_number, slot};
// rsp (source) gives a result word {status, entry, disk_block, block_offset};
// cfg (sink) takes the inode table start block and is always ready; the user must
// write it only while the cache is idle, which the block itself does not enforce.
// Every request except the reserved command gives exactly one result word.
// Timing: a request is taken only while the controller is idle and is resolved in
// the busy state; a new request is not taken until the last one is resolved. The
// resolve is carried out by the cell row: each cell compares its key against the broadcast request,
// a free-entry token ripples down the row to pick the lowest free cell, and
// all cells update together in the resolve cycle.
// The result sits in an output register; while it waits, the next request is
// taken, but its resolve cycle holds until the output register is taken.
// Reset clears every reference count (all entries free), the table start
// block, the output valid flag and the controller. No clearing pass is needed.
module refcounted_inode_cache #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  ric_stream_if.sink   req,
  ric_stream_if.source rsp,
  ric_stream_if.sink   cfg
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  ric_pkg::req_t              req_q;
  logic [ric_pkg::INO_W-1:0]  req_key;
  ric_pkg::cfg_word_t         table_start;
  logic                       rsp_valid;
  ric_pkg::rsp_t              rsp_word;
  ric_pkg::rsp_t              rsp_next;

  logic                       accept;
  logic                       commit;

  ric_pkg::cell_op_t          op;
  logic [TABLE_ENTRIES-1:0]   match_vec;
  logic [TABLE_ENTRIES-1:0]   grant_vec;
  logic [TABLE_ENTRIES:0]     free_chain;
  ric_pkg::cell_view_t        views [TABLE_ENTRIES];
  ric_pkg::cell_view_t        sel_view;

  logic [IDX_W-1:0]           hit_idx;
  logic [IDX_W-1:0]           grant_idx;
  logic                       hit_any;
  logic                       free_any;

  logic [ric_pkg::INO_W-1:0]  place_key;
  logic [ric_pkg::BLK_W-1:0]  place_blk;
  logic [ric_pkg::OFF_W-1:0]  place_off;

  // Map a table index onto the entry field
  function automatic logic [ric_pkg::ENTRY_W-1:0] to_entry(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[ric_pkg::ENTRY_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  assign accept = req.valid && req.ready;
  // Resolve only when the output register is free or being drained
  assign commit = (state == S_BUSY) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_start <= '0;
    end else if (cfg.valid && cfg.ready) begin
      table_start <= cfg.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller: idle until a word arrives, then busy until it is resolved
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_BUSY;
      S_BUSY: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request; the key is inode minus one, which also yields the
  // disk place by shift and mask
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req.data;
      req_key <= req.data.inode_number - ric_pkg::INO_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  assign op.commit  = commit;
  assign op.cmd     = req_q.cmd;
  assign op.hit_any = hit_any;
  assign op.device  = req_q.device;
  assign op.key     = req_key;

  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = (32'(req_q.slot) == 32'(i));

    ric_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .op              (op),
      .sel             (sel),
      .free_before_in  (free_chain[i]),
      .free_before_out (free_chain[i+1]),
      .match           (match_vec[i]),
      .grant           (grant_vec[i]),
      .view            (views[i])
    );
  end

  assign hit_any  = |match_vec;
  assign free_any = free_chain[TABLE_ENTRIES];

  // Encode the single hit and the single grant; gather the addressed cell
  always_comb begin
    hit_idx   = '0;
    grant_idx = '0;
    sel_view  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_vec[i]) hit_idx = hit_idx | IDX_W'(i);
      if (grant_vec[i]) grant_idx = grant_idx | IDX_W'(i);
      sel_view = sel_view | views[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  assign place_key = (req_q.cmd == ric_pkg::CMD_GET) ? req_key : sel_view.key;
  assign place_blk = ric_pkg::BLK_W'(place_key >> ric_pkg::OFF_W) + table_start;
  assign place_off = place_key[ric_pkg::OFF_W-1:0];

  always_comb begin
    rsp_next              = '0;
    rsp_next.entry        = req_q.slot;
    case (req_q.cmd)
      ric_pkg::CMD_GET: begin
        rsp_next.disk_block   = place_blk;
        rsp_next.block_offset = place_off;
        if (hit_any) begin
          rsp_next.status = ric_pkg::STAT_HIT;
          rsp_next.entry  = to_entry(hit_idx);
        end else if (free_any) begin
          rsp_next.status = ric_pkg::STAT_MISS;
          rsp_next.entry  = to_entry(grant_idx);
        end else begin
          rsp_next.status = ric_pkg::STAT_FULL;
          rsp_next.entry  = '0;
        end
      end
      ric_pkg::CMD_PUT: begin
        if (!sel_view.live_sel) begin
          rsp_next.status = ric_pkg::STAT_FREE;
        end else if (!sel_view.last_ref) begin
          rsp_next.status = ric_pkg::STAT_HELD;
        end else if (sel_view.dirty) begin
          rsp_next.status       = ric_pkg::STAT_WRITEBACK;
          rsp_next.disk_block   = place_blk;
          rsp_next.block_offset = place_off;
        end else begin
          rsp_next.status = ric_pkg::STAT_CLEAN;
        end
      end
      ric_pkg::CMD_DIRTY: begin
        rsp_next.status = sel_view.live_sel ? ric_pkg::STAT_MARKED : ric_pkg::STAT_FREE;
      end
      default: begin
      end
    endcase
  end

  // Load on resolve (the reserved command gives nothing), drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit && req_q.cmd != ric_pkg::CMD_NONE) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && req_q.cmd != ric_pkg::CMD_NONE) begin
      rsp_word <= rsp_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY) |-> $onehot0(match_vec))
    else $error("more than one live entry matches the request");

  a_single_grant: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY) |-> $onehot0(grant_vec))
    else $error("free-entry chain granted more than one cell");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_BUSY))
    else $error("accepted request was not taken to resolve");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(commit))
    else $error("result word appeared without a resolve cycle");

  a_grant_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && |grant_vec) |-> free_any)
    else $error("grant given while the row reports no free entry");

endmodule

// ===== rtl/ric_cell.sv =====
// One table entry: key compare, free-slot grant chain link and entry update.
module ric_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ric_pkg::cell_op_t     op,
  input  logic                  sel,
  input  logic                  free_before_in,
  output logic                  free_before_out,
  output logic                  match,
  output logic                  grant,
  output ric_pkg::cell_view_t   view
);

  logic [ric_pkg::DEV_W-1:0]  dev;
  logic [ric_pkg::INO_W-1:0]  key;
  logic [ric_pkg::REFS_W-1:0] refs;
  logic                       dirty;
  logic                       live;
  logic                       live_sel;

  assign live     = (refs != '0);
  assign live_sel = sel && live;
  assign match    = live && (dev == op.device) && (key == op.key);

  // Pass the "a free entry lies below" token on to the next cell
  assign grant           = !live && !free_before_in;
  assign free_before_out = free_before_in || !live;

  assign view.live_sel = live_sel;
  assign view.last_ref = live_sel && (refs == ric_pkg::REFS_ONE);
  assign view.dirty    = live_sel && dirty;
  assign view.key      = live_sel ? key : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      refs <= '0;
    end else if (op.commit) begin
      unique case (op.cmd)
        ric_pkg::CMD_GET: begin
          if (op.hit_any) begin
            if (match && refs != ric_pkg::REFS_MAX) begin
              refs <= refs + ric_pkg::REFS_ONE;
            end
          end else if (grant) begin
            refs <= ric_pkg::REFS_ONE;
          end
        end
        ric_pkg::CMD_PUT: begin
          if (live_sel) begin
            refs <= refs - ric_pkg::REFS_ONE;
          end
        end
        ric_pkg::CMD_DIRTY, ric_pkg::CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op.commit) begin
      unique case (op.cmd)
        ric_pkg::CMD_GET: begin
          if (!op.hit_any && grant) begin
            dev   <= op.device;
            key   <= op.key;
            dirty <= 1'b0;
          end
        end
        ric_pkg::CMD_DIRTY: begin
          if (live_sel) begin
            dirty <= 1'b1;
          end
        end
        ric_pkg::CMD_PUT, ric_pkg::CMD_NONE: begin
        end
      endcase
    end
  end

endmodule
